// File: rtl/irrp_pkg.sv
package irrp_pkg;

  localparam int RUN_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(RUN_DEPTH);
  localparam int CNT_W     = $clog2(RUN_DEPTH + 1);

  localparam logic [7:0] REPEAT_MAX = 8'hff;

  typedef enum logic [1:0] {
    CMD_FRAME  = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // one stored run: mask plus extra frames
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] repeat_cnt;
  } run_entry_t;

  // write-back request from control to run store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    run_entry_t        data;
  } run_wr_t;

endpackage

// File: rtl/irrp_run_ram.sv
module irrp_run_ram
  import irrp_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output run_entry_t        rd_data,
  input  run_wr_t           wr
);

  run_entry_t mem [RUN_DEPTH];
  run_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/input_run_record_playback.sv
// Run-length recorder / player for 8-bit per-frame button masks.
//
// Channels:
//   in_*  : command beat (frame, clear, append run, read run), valid/ready.
//   out_* : one result beat per command beat, valid/ready.
//   cfg_* : mode register write (0 record, 1 playback), always ready.
//           Write it only while no command is in flight.
//
// Timing: a command is taken in the idle cycle, the run store is read at
// that edge, and the execute state then does the modify and write-back and
// loads the result register once that register is free; result valid
// rises as it loads. No new command is taken before the write-back is done.
//
// Stall: the result register holds a finished beat while the next command
// is already accepted and read; that command waits in its write-back cycle
// until the result register frees, so nothing is lost or reordered.
//
// Reset: run count, playback position, frame count and mode clear at once;
// store contents are not cleared; entries at or past the run count may be
// read but their data is never used, so no clearing pass is needed.
module input_run_record_playback
  import irrp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_mode,

  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_command,
  input  logic [7:0]       in_live_buttons,
  input  logic [9:0]       in_run_index,
  input  logic [7:0]       in_run_value_in,
  input  logic [7:0]       in_run_repeat_in,

  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_buttons_out,
  output logic [7:0]       out_run_value_out,
  output logic [7:0]       out_run_repeat_out,
  output logic [CNT_W-1:0] out_runs_stored,
  output logic             out_replay_active,
  output logic [1:0]       out_status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic             mode_r;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [7:0]       fcnt_r, fcnt_nxt;

  // latched command beat
  cmd_t       cmd_r;
  logic [7:0] live_r;
  logic [9:0] idx_r;
  logic [7:0] vin_r;
  logic [7:0] rin_r;

  // result register
  logic       out_valid_r;
  logic [7:0] bout_r, vout_r, rout_r;
  logic [CNT_W-1:0] runs_r;
  logic       active_r;
  status_t    status_r;

  logic [7:0] bout_nxt, vout_nxt, rout_nxt;
  status_t    status_nxt;

  logic              in_fire, exec_fire, full;
  logic [ADDR_W-1:0] rd_addr, last_addr;
  run_entry_t        rd_data;
  run_wr_t           wr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // write-back cycle completes once the result register can take the beat
  assign exec_fire = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  assign full      = (total_r == CNT_W'(RUN_DEPTH));
  assign last_addr = ADDR_W'(total_r - CNT_W'(1));

  // read address for the incoming command
  always_comb begin
    case (cmd_t'(in_command))
      CMD_FRAME: rd_addr = mode_r ? pos_r[ADDR_W-1:0] : last_addr;
      CMD_READ:  rd_addr = ADDR_W'(in_run_index);
      default:   rd_addr = last_addr;
    endcase
  end

  irrp_run_ram u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // modify stage: works on the store data read at acceptance
  always_comb begin
    total_nxt  = total_r;
    pos_nxt    = pos_r;
    fcnt_nxt   = fcnt_r;
    bout_nxt   = '0;
    vout_nxt   = '0;
    rout_nxt   = '0;
    status_nxt = STAT_OK;
    wr.en      = 1'b0;
    wr.addr    = total_r[ADDR_W-1:0];
    wr.data    = '{value: live_r, repeat_cnt: 8'd0};

    case (cmd_r)
      CMD_FRAME: begin
        bout_nxt = live_r;
        if (!mode_r) begin
          if (total_r == '0 || rd_data.value != live_r ||
              rd_data.repeat_cnt == REPEAT_MAX) begin
            // open a new run
            if (full) begin
              status_nxt = STAT_FULL;
            end else begin
              wr.en     = 1'b1;
              total_nxt = total_r + CNT_W'(1);
            end
          end else begin
            // extend last run
            wr.en   = 1'b1;
            wr.addr = last_addr;
            wr.data = '{value: rd_data.value,
                        repeat_cnt: rd_data.repeat_cnt + 8'd1};
          end
        end else if (pos_r < total_r) begin
          bout_nxt = live_r | rd_data.value;
          if (fcnt_r >= rd_data.repeat_cnt) begin
            fcnt_nxt = '0;
            pos_nxt  = pos_r + CNT_W'(1);
          end else begin
            fcnt_nxt = fcnt_r + 8'd1;
          end
        end
      end
      CMD_CLEAR: begin
        total_nxt = '0;
        pos_nxt   = '0;
        fcnt_nxt  = '0;
      end
      CMD_APPEND: begin
        wr.data = '{value: vin_r, repeat_cnt: rin_r};
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          wr.en     = 1'b1;
          total_nxt = total_r + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (CNT_W'(idx_r) < total_r) begin
          vout_nxt = rd_data.value;
          rout_nxt = rd_data.repeat_cnt;
        end else begin
          status_nxt = STAT_RANGE;
        end
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase

    // write-back only on the cycle the beat retires
    wr.en = wr.en && exec_fire;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= 1'b0;
      total_r     <= '0;
      pos_r       <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_mode;
      end
      if (exec_fire) begin
        total_r     <= total_nxt;
        pos_r       <= pos_nxt;
        fcnt_r      <= fcnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= cmd_t'(in_command);
      live_r <= in_live_buttons;
      idx_r  <= in_run_index;
      vin_r  <= in_run_value_in;
      rin_r  <= in_run_repeat_in;
    end
    if (exec_fire) begin
      bout_r   <= bout_nxt;
      vout_r   <= vout_nxt;
      rout_r   <= rout_nxt;
      runs_r   <= total_nxt;
      active_r <= (pos_nxt < total_nxt);
      status_r <= status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_buttons_out    = bout_r;
  assign out_run_value_out  = vout_r;
  assign out_run_repeat_out = rout_r;
  assign out_runs_stored    = runs_r;
  assign out_replay_active  = active_r;
  assign out_status         = status_r;

`ifndef SYNTHESIS
  // one command in flight: acceptance closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("command accepted while another in flight");

  // playback position never runs past the stored runs
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= total_r)
    else $error("playback position beyond run count");

  // a dropped run leaves the run count alone
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && status_nxt == STAT_FULL) |=> $stable(total_r))
    else $error("run count moved on dropped run");

  // no store write outside the write-back state, and only for frame or append
  a_wr_gate: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == ST_EXEC) && (cmd_r == CMD_FRAME || cmd_r == CMD_APPEND))
    else $error("stray run store write");
`endif

endmodule

// File: sim/input_run_record_playback_test.sv
module input_run_record_playback_test;
  import irrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any accepted beat before the run is declared hung
  localparam int STALL_LIMIT = 3000;
  // slots in the outstanding result ring; at most two are ever in use
  localparam int PEND_SLOTS  = 8;

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_mode;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       in_command;
  logic [7:0]       in_live_buttons;
  logic [9:0]       in_run_index;
  logic [7:0]       in_run_value_in;
  logic [7:0]       in_run_repeat_in;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_buttons_out;
  logic [7:0]       out_run_value_out;
  logic [7:0]       out_run_repeat_out;
  logic [CNT_W-1:0] out_runs_stored;
  logic             out_replay_active;
  logic [1:0]       out_status;

  input_run_record_playback dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_mode          (cfg_mode),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_live_buttons   (in_live_buttons),
    .in_run_index      (in_run_index),
    .in_run_value_in   (in_run_value_in),
    .in_run_repeat_in  (in_run_repeat_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_buttons_out   (out_buttons_out),
    .out_run_value_out (out_run_value_out),
    .out_run_repeat_out(out_run_repeat_out),
    .out_runs_stored   (out_runs_stored),
    .out_replay_active (out_replay_active),
    .out_status        (out_status)
  );

  // one result beat as the block should report it
  typedef struct {
    logic [7:0]       buttons;
    logic [7:0]       mask;
    logic [7:0]       extra;
    logic [CNT_W-1:0] stored;
    logic             active;
    status_t          status;
  } run_result_t;

  // ---------------------------------------------------------------------
  // Shadow copy of the run store and the player. Reset values match the
  // block: no runs, playback at the start, record mode.
  // ---------------------------------------------------------------------
  logic [7:0]  mask_mem  [RUN_DEPTH];
  logic [7:0]  extra_mem [RUN_DEPTH];
  int          run_count = 0;
  int          play_idx  = 0;
  int          frame_cnt = 0;
  bit          play_mode = 1'b0;

  // outstanding predictions, oldest at pend_rd
  run_result_t pending_outcomes [PEND_SLOTS];
  int          pend_wr = 0;
  int          pend_rd = 0;
  int          errors = 0;
  bit          calm   = 1'b0;  // set: no idling on either side

  // append one run; false when the store is already full
  function automatic bit push_run(logic [7:0] mask, logic [7:0] extra);
    if (run_count >= RUN_DEPTH) return 1'b0;
    mask_mem[run_count]  = mask;
    extra_mem[run_count] = extra;
    run_count++;
    return 1'b1;
  endfunction

  // advance the shadow state by one command beat, return what it reports
  function automatic run_result_t apply_command(cmd_t cmd, logic [7:0] live,
                                                logic [9:0] idx, logic [7:0] mask,
                                                logic [7:0] extra);
    run_result_t res;
    res.buttons = '0;
    res.mask    = '0;
    res.extra   = '0;
    res.status  = STAT_OK;
    case (cmd)
      CMD_FRAME: begin
        res.buttons = live;
        if (!play_mode) begin
          // new run on empty store, changed mask, or saturated repeat
          if (run_count == 0 || mask_mem[run_count-1] != live ||
              extra_mem[run_count-1] == REPEAT_MAX) begin
            if (!push_run(live, 8'h00)) res.status = STAT_FULL;
          end else begin
            extra_mem[run_count-1] = extra_mem[run_count-1] + 8'd1;
          end
        end else if (play_idx < run_count) begin
          res.buttons = live | mask_mem[play_idx];
          if (frame_cnt >= extra_mem[play_idx]) begin
            frame_cnt = 0;
            play_idx++;
          end else begin
            frame_cnt++;
          end
        end
        // past the end of playback the live mask passes untouched
      end
      CMD_CLEAR: begin
        run_count = 0;
        play_idx  = 0;
        frame_cnt = 0;
      end
      CMD_APPEND: begin
        if (!push_run(mask, extra)) res.status = STAT_FULL;
      end
      CMD_READ: begin
        if (idx < run_count) begin
          res.mask  = mask_mem[idx];
          res.extra = extra_mem[idx];
        end else begin
          res.status = STAT_RANGE;
        end
      end
    endcase
    res.stored = CNT_W'(run_count);
    res.active = (play_idx < run_count);
    return res;
  endfunction

  function automatic void check_field(string what, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. Config and command
  // beats update the shadow state; every result beat is held against the
  // oldest outstanding prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    run_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) play_mode = cfg_mode;
      if (in_valid && in_ready) begin
        pending_outcomes[pend_wr % PEND_SLOTS] =
          apply_command(cmd_t'(in_command), in_live_buttons, in_run_index,
                        in_run_value_in, in_run_repeat_in);
        pend_wr++;
      end
      if (out_valid && out_ready) begin
        if (pend_wr == pend_rd) begin
          errors++;
          $display("%0t: result beat with nothing outstanding", $time);
        end else begin
          want = pending_outcomes[pend_rd % PEND_SLOTS];
          pend_rd++;
          check_field("buttons_out",    11'(want.buttons), 11'(out_buttons_out));
          check_field("run_value_out",  11'(want.mask),    11'(out_run_value_out));
          check_field("run_repeat_out", 11'(want.extra),   11'(out_run_repeat_out));
          check_field("runs_stored",    11'(want.stored),  11'(out_runs_stored));
          check_field("replay_active",  11'(want.active),  11'(out_replay_active));
          check_field("status",         11'(want.status),  11'(out_status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any accepted beat on any channel restarts the count.
  // ---------------------------------------------------------------------
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side backpressure: ready stretches, sometimes broken by stall
  // bursts unless idling is off.
  // ---------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers. All called and returning at a falling edge.
  // ---------------------------------------------------------------------
  task automatic send_beat(cmd_t cmd, logic [7:0] live, logic [9:0] idx,
                           logic [7:0] mask, logic [7:0] extra);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_command       = cmd;
    in_live_buttons  = live;
    in_run_index     = idx;
    in_run_value_in  = mask;
    in_run_repeat_in = extra;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // unused fields carry random junk so the block must ignore them
  task automatic frame_beat(logic [7:0] live);
    send_beat(CMD_FRAME, live, 10'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic clear_beat();
    send_beat(CMD_CLEAR, 8'($urandom), 10'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic append_beat(logic [7:0] mask, logic [7:0] extra);
    send_beat(CMD_APPEND, 8'($urandom), 10'($urandom), mask, extra);
  endtask

  task automatic read_beat(logic [9:0] idx);
    send_beat(CMD_READ, 8'($urandom), idx, 8'($urandom), 8'($urandom));
  endtask

  // hold off until every outstanding result is back, plus pipeline slack
  task automatic settle();
    while (pend_wr != pend_rd) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mode register only changes with the block idle
  task automatic write_mode(bit m);
    settle();
    cfg_valid = 1'b1;
    cfg_mode  = m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // record mode straight out of reset: run building, repeat saturation,
  // explicit appends at the repeat extremes, reads in and out of range
  task automatic test_record_directed();
    read_beat(10'd0);              // empty store, out of range
    frame_beat(8'h00);             // opens run 0
    frame_beat(8'h00);             // extends it
    frame_beat(8'hff);             // mask change, run 1
    frame_beat(8'hff);
    frame_beat(8'h5a);             // run 2
    append_beat(8'ha5, 8'hfe);     // run 3, one short of saturation
    frame_beat(8'ha5);             // repeat reaches 0xff
    frame_beat(8'ha5);             // saturated: opens run 4
    append_beat(8'hff, 8'h00);     // run 5
    append_beat(8'h00, 8'hff);     // run 6, born saturated
    frame_beat(8'h00);             // must open run 7, not extend
    read_beat(10'd0);
    read_beat(10'd3);
    read_beat(10'd7);
    read_beat(10'd8);              // first index past the end
    read_beat(10'h3ff);
  endtask

  // playback: empty store, repeat counting, end of playback, late append
  task automatic test_playback_directed();
    write_mode(1'b1);
    clear_beat();
    frame_beat(8'h0f);             // nothing to play, live only
    append_beat(8'h01, 8'h00);
    append_beat(8'h02, 8'h02);
    append_beat(8'h80, 8'h01);
    frame_beat(8'h00);             // run 0, one frame
    frame_beat(8'h10);             // run 1, three frames
    frame_beat(8'h00);
    frame_beat(8'h10);
    frame_beat(8'h00);             // run 2, two frames
    frame_beat(8'h00);
    frame_beat(8'h21);             // past the end, passes live
    append_beat(8'h40, 8'h00);     // appended after the end
    frame_beat(8'h00);             // plays the new run
    frame_beat(8'hff);             // past the end again
    read_beat(10'd2);
    clear_beat();                  // position back to the start
    frame_beat(8'h01);
    write_mode(1'b0);
  endtask

  // random traffic in phases; each phase starts idle with a fresh mode
  task automatic test_random_traffic();
    logic [7:0] live;
    int         pick;
    live = 8'h00;
    clear_beat();
    for (int phase = 0; phase < 10; phase++) begin
      // the last part runs with no idling at all
      if (phase >= 8) calm = 1'b1;
      write_mode(phase < 8 ? phase[0] : 1'($urandom_range(0, 1)));
      for (int n = 0; n < 80; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          clear_beat();
        end else if (pick < 16) begin
          // mostly short runs so playback keeps moving
          append_beat(8'($urandom), $urandom_range(0, 4) == 0 ? 8'($urandom)
                                                              : 8'($urandom_range(0, 3)));
        end else if (pick < 34) begin
          if (run_count > 0 && $urandom_range(0, 3) != 0)
            read_beat(10'($urandom_range(0, run_count - 1)));
          else
            read_beat(10'($urandom));
        end else begin
          // held masks build real runs; fresh ones come from a small set
          if ($urandom_range(0, 9) >= 7)
            live = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
          frame_beat(live);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_mode         = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_FRAME;
    in_live_buttons  = '0;
    in_run_index     = '0;
    in_run_value_in  = '0;
    in_run_repeat_in = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_record_directed();
    test_playback_directed();
    test_random_traffic();

    calm = 1'b1;
    settle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/irrp_pkg.sv
rtl/irrp_run_ram.sv
rtl/input_run_record_playback.sv
sim/input_run_record_playback_test.sv
